/* hdl/sen_pkg.sv */
// Shared types, constants and helpers for the scaled Euclidean norm block.
`default_nettype none
package sen_pkg;

  localparam int FW_DEFAULT = 64;

  localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] PINF_BITS = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] ZERO_BITS = 64'h0000_0000_0000_0000;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_ADD,
    OP_SQRT
  } fp_op_t;

  typedef struct packed {
    logic   start;
    fp_op_t op;
  } fpu_req_t;

  function automatic logic is_nan(input logic [63:0] x);
    return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
  endfunction

  function automatic logic is_inf(input logic [63:0] x);
    return (x[62:52] == 11'h7FF) && (x[51:0] == 52'd0);
  endfunction

  function automatic logic is_zero(input logic [63:0] x);
    return x[62:0] == 63'd0;
  endfunction

endpackage
`default_nettype wire

/* hdl/scaled_euclidean_norm.sv */
// Top level: streaming scaled Euclidean norm over double vector elements.
//
// Input stream: one element word per transfer, s_tdata holds the raw double,
// s_tlast marks the final element of a vector. Output stream: one norm word
// per vector on m_tdata, masked to FLOAT_WIDTH bits.
// Each element runs through one shared iterative double unit: a divide,
// one or two multiplies and an add whose alignment is set by the exponent
// gap. An operation with a zero, infinite or NaN operand finishes straight
// from idle, without iterating. Subnormal operands add normalize steps.
// Zero and NaN elements skip the divide, multiply and add. The final
// element adds a square root and a multiply before loading the norm word.
// s_tready is high only while the sequencer is idle and out of reset.
// The norm word sits in an output register; a stalled receiver only blocks
// the next norm, the next vector's elements are still taken.
// Reset clears the scale to 0.0, the sum to 1.0 and empties the output.
`default_nettype none
module scaled_euclidean_norm
  import sen_pkg::*;
#(
  parameter int FLOAT_WIDTH = FW_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // element[63:0]
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata    // norm[63:0]
);

  localparam logic [63:0] OUT_MASK = {64{1'b1}} >> (64 - FLOAT_WIDTH);

  typedef enum logic [3:0] {
    T_IDLE, T_BDIV, T_BMUL1, T_BMUL2, T_BADD, T_SDIV, T_SMUL, T_SADD,
    T_SQRT, T_FMUL, T_EMIT
  } tstate_t;

  tstate_t     state;
  logic [63:0] scale, ssq, xa, r, t;
  logic        last;
  logic        issued;

  fpu_req_t    req;
  logic [63:0] fa, fb, fres;
  logic        fdone;
  logic [63:0] ax_in;

  assign s_tready = (state == T_IDLE) && !rst;
  assign ax_in    = {1'b0, s_tdata[62:0]};

  always_comb begin
    req.start = (state != T_IDLE) && (state != T_EMIT) && !issued;
    req.op    = OP_MUL;
    fa        = scale;
    fb        = t;
    unique case (state)
      T_BDIV:  begin req.op = OP_DIV;  fa = scale; fb = xa; end
      T_BMUL1: begin req.op = OP_MUL;  fa = ssq;   fb = r;  end
      T_BMUL2: begin req.op = OP_MUL;  fa = t;     fb = r;  end
      T_BADD:  begin req.op = OP_ADD;  fa = ONE_BITS; fb = t; end
      T_SDIV:  begin req.op = OP_DIV;  fa = xa;    fb = scale; end
      T_SMUL:  begin req.op = OP_MUL;  fa = r;     fb = r;  end
      T_SADD:  begin req.op = OP_ADD;  fa = ssq;   fb = t;  end
      T_SQRT:  begin req.op = OP_SQRT; fa = ssq;   fb = ssq; end
      default: begin req.op = OP_MUL;  fa = scale; fb = t;  end
    endcase
  end

  sen_fpu u_fpu (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .a    (fa),
    .b    (fb),
    .done (fdone),
    .res  (fres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= T_IDLE;
      issued   <= 1'b0;
      scale    <= ZERO_BITS;
      ssq      <= ONE_BITS;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (req.start) issued <= 1'b1;
      if (fdone) issued <= 1'b0;
      unique case (state)
        T_IDLE: begin
          if (s_tvalid) begin
            xa   <= ax_in;
            last <= s_tlast;
            if (is_nan(s_tdata)) begin
              ssq <= QNAN_BITS;
              if (s_tlast) state <= T_SQRT;
            end else if (ax_in == ZERO_BITS) begin
              if (s_tlast) state <= T_SQRT;
            end else if (scale < ax_in) begin
              state <= T_BDIV;
            end else begin
              state <= T_SDIV;
            end
          end
        end
        T_BDIV:  if (fdone) begin r <= fres; state <= T_BMUL1; end
        T_BMUL1: if (fdone) begin t <= fres; state <= T_BMUL2; end
        T_BMUL2: if (fdone) begin t <= fres; state <= T_BADD; end
        T_BADD: begin
          if (fdone) begin
            ssq   <= fres;
            scale <= xa;
            state <= last ? T_SQRT : T_IDLE;
          end
        end
        T_SDIV:  if (fdone) begin r <= fres; state <= T_SMUL; end
        T_SMUL:  if (fdone) begin t <= fres; state <= T_SADD; end
        T_SADD: begin
          if (fdone) begin
            ssq   <= fres;
            state <= last ? T_SQRT : T_IDLE;
          end
        end
        T_SQRT:  if (fdone) begin t <= fres; state <= T_FMUL; end
        T_FMUL:  if (fdone) begin r <= fres; state <= T_EMIT; end
        T_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= r & OUT_MASK;
            m_tvalid <= 1'b1;
            scale    <= ZERO_BITS;
            ssq      <= ONE_BITS;
            state    <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/sen_fpu.sv */
// Shared iterative double unit for nonnegative operands: multiply, divide, add, square root.
`default_nettype none
module sen_fpu
  import sen_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire fpu_req_t    req,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      res
);

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_MUL, S_DIV, S_SQRT, S_ALIGN, S_FIN, S_DENORM, S_ROUND
  } state_t;

  state_t state;
  fp_op_t op;

  logic [52:0]        ma, mb;
  logic signed [13:0] ea, eb, be;
  logic [111:0]       p;
  logic [59:0]        rem;
  logic [55:0]        q, sig;
  logic               stk;
  logic [5:0]         cnt;

  logic               na, nb, ia, ib, za, zb;
  logic               spec;
  logic [63:0]        spec_val;
  logic signed [13:0] diff, sexp;
  logic [53:0]        upper;
  logic               dge, sge;
  logic [55:0]        ddif;
  logic [59:0]        r4, trial;
  logic [56:0]        sum;
  logic               up;
  logic [53:0]        mant;
  logic signed [13:0] ber;
  logic [63:0]        packed_val;

  always_comb begin
    na = is_nan(a);
    nb = is_nan(b);
    ia = is_inf(a);
    ib = is_inf(b);
    za = is_zero(a);
    zb = is_zero(b);
    spec = 1'b0;
    spec_val = ZERO_BITS;
    unique case (req.op)
      OP_MUL: begin
        spec = na | nb | ia | ib | za | zb;
        if (na | nb | (ia & zb) | (za & ib)) spec_val = QNAN_BITS;
        else if (ia | ib) spec_val = PINF_BITS;
        else spec_val = ZERO_BITS;
      end
      OP_DIV: begin
        spec = na | nb | ia | ib | za | zb;
        if (na | nb | (za & zb) | (ia & ib)) spec_val = QNAN_BITS;
        else if (ia | zb) spec_val = PINF_BITS;
        else spec_val = ZERO_BITS;
      end
      OP_ADD: begin
        spec = na | nb | ia | ib | za | zb;
        if (na | nb) spec_val = QNAN_BITS;
        else if (ia | ib) spec_val = PINF_BITS;
        else if (za) spec_val = {1'b0, b[62:0]};
        else spec_val = {1'b0, a[62:0]};
      end
      OP_SQRT: begin
        spec = na | ia | za;
        if (na) spec_val = QNAN_BITS;
        else if (ia) spec_val = PINF_BITS;
        else spec_val = ZERO_BITS;
      end
      default: begin
        spec = 1'b1;
        spec_val = QNAN_BITS;
      end
    endcase

    diff  = ea - eb;
    sexp  = ea - 14'sd1023;
    upper = {1'b0, p[105:53]} + (p[0] ? {1'b0, ma} : 54'd0);
    dge   = rem[55:0] >= {3'b000, mb};
    ddif  = rem[55:0] - {3'b000, mb};
    r4    = {rem[57:0], p[111:110]};
    trial = {2'b00, q, 2'b01};
    sge   = r4 >= trial;
    sum   = {1'b0, ma, 3'b000} + {1'b0, q};

    up   = sig[2] & (sig[3] | sig[1] | sig[0] | stk);
    mant = {1'b0, sig[55:3]} + {53'd0, up};
    ber  = mant[53] ? be + 14'sd1 : be;
    if (ber >= 14'sd2047) packed_val = PINF_BITS;
    else packed_val = {1'b0, (mant[53] | mant[52]) ? ber[10:0] : 11'd0,
                       mant[53] ? 52'd0 : mant[51:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            op <= req.op;
            if (spec) begin
              res  <= spec_val;
              done <= 1'b1;
            end else begin
              ma <= {a[62:52] != 11'd0, a[51:0]};
              ea <= (a[62:52] == 11'd0) ? 14'sd1 : $signed({3'b000, a[62:52]});
              if (req.op == OP_SQRT) begin
                mb <= {1'b1, 52'd0};
                eb <= 14'sd1023;
              end else begin
                mb <= {b[62:52] != 11'd0, b[51:0]};
                eb <= (b[62:52] == 11'd0) ? 14'sd1 : $signed({3'b000, b[62:52]});
              end
              state <= S_NORM;
            end
          end
        end
        S_NORM: begin
          if (!ma[52]) begin
            ma <= {ma[51:0], 1'b0};
            ea <= ea - 14'sd1;
          end
          if (!mb[52]) begin
            mb <= {mb[51:0], 1'b0};
            eb <= eb - 14'sd1;
          end
          if (ma[52] && mb[52]) begin
            cnt <= 6'd0;
            q   <= 56'd0;
            rem <= 60'd0;
            stk <= 1'b0;
            unique case (op)
              OP_MUL: begin
                p     <= {59'd0, mb};
                state <= S_MUL;
              end
              OP_DIV: begin
                if (ma < mb) begin
                  rem <= {6'd0, ma, 1'b0};
                  be  <= diff + 14'sd1022;
                end else begin
                  rem <= {7'd0, ma};
                  be  <= diff + 14'sd1023;
                end
                state <= S_DIV;
              end
              OP_SQRT: begin
                if (sexp[0]) begin
                  p  <= {ma, 1'b0, 58'd0};
                  be <= ((sexp - 14'sd1) >>> 1) + 14'sd1023;
                end else begin
                  p  <= {1'b0, ma, 58'd0};
                  be <= (sexp >>> 1) + 14'sd1023;
                end
                state <= S_SQRT;
              end
              OP_ADD: begin
                if (diff >= 14'sd0) begin
                  q  <= {mb, 3'b000};
                  be <= ea;
                  if (diff > 14'sd58) begin
                    q   <= 56'd0;
                    stk <= 1'b1;
                  end else begin
                    cnt <= diff[5:0];
                  end
                end else begin
                  ma <= mb;
                  q  <= {ma, 3'b000};
                  be <= eb;
                  if (diff < -14'sd58) begin
                    q   <= 56'd0;
                    stk <= 1'b1;
                  end else begin
                    cnt <= 6'(-diff);
                  end
                end
                state <= S_ALIGN;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_MUL: begin
          p   <= {6'd0, upper, p[52:1]};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd52) state <= S_FIN;
        end
        S_DIV: begin
          q   <= {q[54:0], dge};
          rem <= {3'b000, dge ? ddif : rem[55:0], 1'b0};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd55) state <= S_FIN;
        end
        S_SQRT: begin
          q   <= {q[54:0], sge};
          rem <= sge ? r4 - trial : r4;
          p   <= {p[109:0], 2'b00};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd55) state <= S_FIN;
        end
        S_ALIGN: begin
          if (cnt != 6'd0) begin
            stk <= stk | q[0];
            q   <= {1'b0, q[55:1]};
            cnt <= cnt - 6'd1;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          unique case (op)
            OP_MUL: begin
              if (p[105]) begin
                sig <= p[105:50];
                stk <= |p[49:0];
                be  <= ea + eb - 14'sd1022;
              end else begin
                sig <= p[104:49];
                stk <= |p[48:0];
                be  <= ea + eb - 14'sd1023;
              end
            end
            OP_ADD: begin
              if (sum[56]) begin
                sig <= sum[56:1];
                stk <= stk | sum[0];
                be  <= be + 14'sd1;
              end else begin
                sig <= sum[55:0];
              end
            end
            default: begin
              sig <= q;
              stk <= rem != 60'd0;
            end
          endcase
          state <= S_DENORM;
        end
        S_DENORM: begin
          if (be > 14'sd0) begin
            state <= S_ROUND;
          end else if (be < -14'sd60) begin
            sig <= 56'd0;
            stk <= 1'b1;
            be  <= 14'sd1;
          end else begin
            sig <= {1'b0, sig[55:1]};
            stk <= stk | sig[0];
            be  <= be + 14'sd1;
          end
        end
        S_ROUND: begin
          res   <= packed_val;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/sen_chk.sv */
// Port-level checker for the scaled Euclidean norm block, with its bind.
`default_nettype none
module sen_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [63:0] s_tdata,
  input wire logic        s_tlast,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("norm word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("norm word changed while stalled");

  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("ready after last element before norm computed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_sign_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[63])
    else $error("negative norm word");

endmodule

bind scaled_euclidean_norm sen_chk u_chk (.*);
`default_nettype wire
